// ===== sv/bbc_pkg.sv =====
// Shared types and constants of the block buffer cache.
`default_nettype none

package bbc_pkg;

	localparam int NUM_BUFFERS = 32;
	localparam int SLOT_W      = $clog2(NUM_BUFFERS);
	localparam int CNT_W       = $clog2(NUM_BUFFERS + 1);
	localparam int XW          = (SLOT_W > 5) ? SLOT_W : 5;

	localparam logic [31:0] STAMP_NONE = 32'hffff_ffff;
	localparam logic [7:0]  COUNT_MAX  = 8'hff;

	typedef enum logic [1:0] {
		OP_READ    = 2'd0,
		OP_RELEASE = 2'd1,
		OP_PIN     = 2'd2,
		OP_UNPIN   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOBUF  = 2'd1,
		ST_MISUSE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_MOD
	} state_t;

	// One buffer descriptor as kept in the tag memory
	typedef struct packed {
		logic [7:0]  dev;
		logic [31:0] blk;
		logic [7:0]  cnt;
		logic [31:0] stamp;
		logic        filled;
	} entry_t;

	localparam int ENT_W = $bits(entry_t);

	// Outcome of a full tag scan
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] hit_idx;
		entry_t            hit_ent;
		logic              found;
		logic [SLOT_W-1:0] best_idx;
		logic [31:0]       best_stamp;
	} scan_res_t;

endpackage

`default_nettype wire

// ===== sv/bbc_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
`default_nettype none

module bbc_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8
) (
	input  wire                      clk,
	input  wire                      wen,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire                      ren,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (ren) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/bbc_scan.sv =====
// Tag match and least-recently-released victim tracker over a stream of entries.
`default_nettype none

module bbc_scan import bbc_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                clr,
	input  wire                beat,
	input  wire [SLOT_W-1:0]   idx,
	input  entry_t             ent,
	input  wire [7:0]          dev,
	input  wire [31:0]         blk,
	output scan_res_t          res
);

	logic              hit_q;
	logic              found_q;
	logic [SLOT_W-1:0] hit_idx_q;
	entry_t            hit_ent_q;
	logic [SLOT_W-1:0] best_idx_q;
	logic [31:0]       best_time_q;
	logic              match;
	logic              better;

	assign match  = (ent.dev == dev) && (ent.blk == blk);
	assign better = (ent.cnt == 8'd0) && (ent.stamp < best_time_q);

	// Track flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (clr) begin
			hit_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (beat) begin
			if (match) begin
				hit_q <= 1'b1;
			end
			if (better) begin
				found_q <= 1'b1;
			end
		end
	end

	// Hold first match and best victim so far
	always_ff @(posedge clk) begin
		if (clr) begin
			best_time_q <= STAMP_NONE;
		end else if (beat) begin
			if (match && !hit_q) begin
				hit_idx_q <= idx;
				hit_ent_q <= ent;
			end
			if (better) begin
				best_idx_q  <= idx;
				best_time_q <= ent.stamp;
			end
		end
	end

	assign res = '{hit: hit_q, hit_idx: hit_idx_q, hit_ent: hit_ent_q,
		found: found_q, best_idx: best_idx_q, best_stamp: best_time_q};

endmodule

`default_nettype wire

// ===== sv/block_buffer_cache_lru_top.sv =====
// Top level of the block buffer cache: sequencer, tag memory and result port.
//
// A read request scans every buffer descriptor out of one tag memory, one
// entry per cycle through its single read port, then writes back the hit or
// the chosen victim, if there is one. A read issues one memory read per
// entry, takes in the last read data, decides and writes back in S_DECIDE,
// and then raises done. Release, pin and unpin read one entry, modify it and
// write it back; a slot number beyond the table is answered without a memory
// access. busy stays high while an item is in work. The result is shown for
// one cycle with done high and the receiver cannot stall it; the next start
// may be issued in the same cycle as done, so a new item is taken only once
// the previous one has been answered.
`default_nettype none

module block_buffer_cache_lru_top import bbc_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  opcode,
	input  wire  [7:0]  device_id,
	input  wire  [31:0] block_number,
	input  wire  [4:0]  slot_in,
	input  wire  [31:0] current_tick,
	output logic        done,
	output logic [4:0]  slot_out,
	output logic        need_fill,
	output logic [1:0]  status,
	output logic [7:0]  ref_count_out
);

	function automatic logic [SLOT_W-1:0] to_idx(input logic [4:0] s);
		logic [XW-1:0] t;
		t = XW'(s);
		return t[SLOT_W-1:0];
	endfunction

	function automatic logic [4:0] to_slot(input logic [SLOT_W-1:0] i);
		logic [XW-1:0] t;
		t = XW'(i);
		return t[4:0];
	endfunction

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  addr_q, addr_d;
	op_t               op_q;
	logic [7:0]        dev_q;
	logic [31:0]       blk_q;
	logic [SLOT_W-1:0] idx_q;
	logic [31:0]       tick_q;

	logic              ren, wen, scan_issue, scan_clr, capture;
	logic [SLOT_W-1:0] raddr, waddr;
	entry_t            wdata;
	logic [ENT_W-1:0]  rdata;
	entry_t            ent_rd;

	logic [NUM_BUFFERS-1:0] ent_vld_q;
	logic              vld_s1, scan_s1;
	logic [SLOT_W-1:0] idx_s1;

	scan_res_t         sres;

	logic              res_load;
	logic [4:0]        res_slot;
	logic              res_fill;
	status_t           res_st;
	logic [7:0]        res_cnt;
	logic              done_q;
	logic [4:0]        slot_q;
	logic              fill_q;
	status_t           st_q;
	logic [7:0]        cnt_q;

	logic              slot_ok;

	assign slot_ok = 32'(slot_in) < 32'(NUM_BUFFERS);

	bbc_ram #(.DEPTH(NUM_BUFFERS), .WIDTH(ENT_W)) u_ram (
		.clk   (clk),
		.wen   (wen),
		.waddr (waddr),
		.wdata (wdata),
		.ren   (ren),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Entries never written read as the reset descriptor
	assign ent_rd = vld_s1 ? entry_t'(rdata) : '0;

	bbc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (scan_clr),
		.beat   (scan_s1),
		.idx    (idx_s1),
		.ent    (ent_rd),
		.dev    (dev_q),
		.blk    (blk_q),
		.res    (sres)
	);

	// State and scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			addr_q  <= '0;
			scan_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			scan_s1 <= scan_issue;
			done_q  <= res_load;
		end
	end

	// Written-entry flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (wen) begin
			ent_vld_q[waddr] <= 1'b1;
		end
	end

	// Read beat side information
	always_ff @(posedge clk) begin
		if (ren) begin
			vld_s1 <= ent_vld_q[raddr];
			idx_s1 <= raddr;
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (capture) begin
			op_q   <= op_t'(opcode);
			dev_q  <= device_id;
			blk_q  <= block_number;
			idx_q  <= to_idx(slot_in);
			tick_q <= current_tick;
		end
	end

	// Hold the result for its strobe cycle
	always_ff @(posedge clk) begin
		if (res_load) begin
			slot_q <= res_slot;
			fill_q <= res_fill;
			st_q   <= res_st;
			cnt_q  <= res_cnt;
		end
	end

	// Sequence: next state, memory access and result
	always_comb begin
		state_d    = state_q;
		addr_d     = addr_q;
		ren        = 1'b0;
		raddr      = '0;
		wen        = 1'b0;
		waddr      = '0;
		wdata      = '0;
		scan_issue = 1'b0;
		scan_clr   = 1'b0;
		capture    = 1'b0;
		res_load   = 1'b0;
		res_slot   = '0;
		res_fill   = 1'b0;
		res_st     = ST_OK;
		res_cnt    = '0;
		busy       = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					capture = 1'b1;
					if (op_t'(opcode) == OP_READ) begin
						scan_clr   = 1'b1;
						ren        = 1'b1;
						raddr      = '0;
						scan_issue = 1'b1;
						addr_d     = CNT_W'(1);
						state_d    = S_SCAN;
					end else if (!slot_ok) begin
						res_load = 1'b1;
						res_slot = slot_in;
						res_st   = ST_MISUSE;
					end else begin
						ren     = 1'b1;
						raddr   = to_idx(slot_in);
						state_d = S_MOD;
					end
				end
			end
			S_SCAN: begin
				if (addr_q < CNT_W'(NUM_BUFFERS)) begin
					ren        = 1'b1;
					raddr      = addr_q[SLOT_W-1:0];
					scan_issue = 1'b1;
					addr_d     = addr_q + CNT_W'(1);
				end
				if (scan_s1 && idx_s1 == SLOT_W'(NUM_BUFFERS - 1)) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				res_load = 1'b1;
				state_d  = S_IDLE;
				if (sres.hit) begin
					wen          = 1'b1;
					waddr        = sres.hit_idx;
					wdata        = sres.hit_ent;
					wdata.filled = 1'b1;
					if (sres.hit_ent.cnt == COUNT_MAX) begin
						res_st = ST_MISUSE;
					end else begin
						wdata.cnt = sres.hit_ent.cnt + 8'd1;
					end
					res_slot = to_slot(sres.hit_idx);
					res_fill = !sres.hit_ent.filled;
					res_cnt  = wdata.cnt;
				end else if (sres.found) begin
					wen      = 1'b1;
					waddr    = sres.best_idx;
					wdata    = '{dev: dev_q, blk: blk_q, cnt: 8'd1,
						stamp: sres.best_stamp, filled: 1'b1};
					res_slot = to_slot(sres.best_idx);
					res_fill = 1'b1;
					res_cnt  = 8'd1;
				end else begin
					res_st = ST_NOBUF;
				end
			end
			S_MOD: begin
				res_load = 1'b1;
				state_d  = S_IDLE;
				wen      = 1'b1;
				waddr    = idx_q;
				wdata    = ent_rd;
				if (op_q == OP_PIN) begin
					if (ent_rd.cnt == COUNT_MAX) begin
						res_st = ST_MISUSE;
					end else begin
						wdata.cnt = ent_rd.cnt + 8'd1;
					end
				end else begin
					if (ent_rd.cnt == 8'd0) begin
						res_st = ST_MISUSE;
					end else begin
						wdata.cnt = ent_rd.cnt - 8'd1;
						if (op_q == OP_RELEASE && ent_rd.cnt == 8'd1) begin
							wdata.stamp = tick_q;
						end
					end
				end
				res_slot = to_slot(idx_q);
				res_cnt  = wdata.cnt;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign done          = done_q;
	assign slot_out      = slot_q;
	assign need_fill     = fill_q;
	assign status        = st_q;
	assign ref_count_out = cnt_q;

	// An accepted item is either in work or answered in the next cycle
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither in work nor answered");

	// No-buffer result carries an empty payload
	a_nobuf_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_NOBUF) |-> (slot_out == 5'd0 && !need_fill &&
		ref_count_out == 8'd0))
		else $error("no-buffer result with non-empty payload");

	// Decision follows the last scan beat
	a_decide_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |-> $past(scan_s1))
		else $error("decision without completed scan");

	// Write-back never overlaps a memory read
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		wen |-> !ren)
		else $error("memory read during write-back");

	// Fill request only on reads
	a_fill_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && need_fill) |-> (status != ST_NOBUF && $past(state_q) == S_DECIDE))
		else $error("fill request outside a read");

endmodule

`default_nettype wire
